// File: sv/cbl_pkg.sv
package cbl_pkg;

    // Field types
    typedef logic signed [31:0] coord_t;
    typedef logic signed [15:0] comp_t;
    typedef logic signed [47:0] prod_t;
    typedef logic signed [49:0] psum_t;
    typedef logic [47:0]        axis_t;
    typedef logic [63:0]        limits_t;

    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 64;
    localparam int FracDrop  = 14;

    // Register indexes of the configuration port
    typedef enum logic [CfgIndexW-1:0] {
        REG_RIGHT_AXIS = 3'd0,
        REG_UP_AXIS    = 3'd1,
        REG_DIR_AXIS   = 3'd2,
        REG_U_LIMITS   = 3'd3,
        REG_V_LIMITS   = 3'd4,
        REG_DEPTH      = 3'd5
    } cfg_index_t;

    // Footprint classes
    typedef enum logic [1:0] {
        CLS_INVALID  = 2'd0,
        CLS_OUTSIDE  = 2'd1,
        CLS_INSIDE   = 2'd2,
        CLS_STRADDLE = 2'd3
    } class_t;

    localparam axis_t RightAxisReset = 48'h0000_0000_4000;
    localparam axis_t UpAxisReset    = 48'h0000_4000_0000;
    localparam axis_t DirAxisReset   = 48'h4000_0000_0000;

    localparam coord_t CoordMax = 32'sh7FFF_FFFF;
    localparam coord_t CoordMin = 32'sh8000_0000;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec3_t;

    // Configuration register set as seen by the datapath
    typedef struct packed {
        axis_t   right_axis;
        axis_t   up_axis;
        axis_t   dir_axis;
        limits_t u_limits;
        limits_t v_limits;
        limits_t depth_limits;
    } cfg_t;

    // Projection extents of one box
    typedef struct packed {
        coord_t min_u;
        coord_t max_u;
        coord_t min_v;
        coord_t max_v;
        coord_t min_w;
        coord_t max_w;
    } extent_t;

    // Q16.16 times Q2.14, exact
    function automatic prod_t mul_q(input coord_t a, input comp_t b);
        prod_t p;
        p = a * b;
        return p;
    endfunction

    // Drop the low fraction bits (floor) and clamp to 32 bits
    function automatic coord_t sat_floor(input psum_t s);
        logic signed [35:0] q;
        coord_t r;
        q = s[49:FracDrop];
        if (q[35:31] == 5'b00000 || q[35:31] == 5'b11111)
            r = q[31:0];
        else if (q[35])
            r = CoordMin;
        else
            r = CoordMax;
        return r;
    endfunction

endpackage

// File: sv/caster_box_light_space_classifier_core.sv
// Light-space box classifier.
// Input channel (item_valid / item_stall) carries one world-space box word:
// box_valid plus min and max corners in signed Q16.16. The box is projected
// onto the configured right, up and direction axes; the result word gives
// the U, V and W extents, the footprint class against the receiver square,
// the near / far depth flags and the inside / outside depth flags. An
// invalid box returns class invalid and all other fields zero.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; ready
// is always high. Write registers only while no box is in flight.
// Pipeline: input register, product, sort, sum/clamp and result register:
// five register stages. Throughput: one box per cycle while the result
// channel is not stalled.
// A stall on the result channel freezes the whole pipeline and is passed
// straight back to item_stall; the pending result word holds its value.
// Reset clears the pipeline valid bits and loads the unit basis vectors and
// zero limits.
module caster_box_light_space_classifier_core
    import cbl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 box_valid,
    input  logic signed [31:0]   box_min_x,
    input  logic signed [31:0]   box_min_y,
    input  logic signed [31:0]   box_min_z,
    input  logic signed [31:0]   box_max_x,
    input  logic signed [31:0]   box_max_y,
    input  logic signed [31:0]   box_max_z,

    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [1:0]           footprint_class,
    output logic signed [31:0]   extent_min_u,
    output logic signed [31:0]   extent_max_u,
    output logic signed [31:0]   extent_min_v,
    output logic signed [31:0]   extent_max_v,
    output logic signed [31:0]   extent_min_w,
    output logic signed [31:0]   extent_max_w,
    output logic                 clipped_near,
    output logic                 clipped_far,
    output logic                 inside_depth,
    output logic                 outside_depth,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    localparam int Stages = 5;

    cfg_t    cfg;
    logic    en;
    vec3_t   lo_reg;
    vec3_t   hi_reg;
    logic    [Stages-1:0] stage_v_reg;
    logic    [Stages-1:0] stage_v_next;
    logic    [Stages-2:0] box_ok_reg;
    logic    [Stages-2:0] box_ok_next;
    extent_t ext;
    extent_t ext_out;
    class_t  cls;

    assign cfg_ready = 1'b1;

    cbl_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance unless a finished word is held by the receiver
    assign en         = !(stage_v_reg[Stages-1] && result_stall);
    assign item_stall = !en;

    // Shift the valid and box flags along with the data
    always_comb
    begin
        stage_v_next = stage_v_reg;
        box_ok_next  = box_ok_reg;
        if (en)
        begin
            stage_v_next = {stage_v_reg[Stages-2:0], item_valid};
            box_ok_next  = {box_ok_reg[Stages-3:0], box_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= '0;
        end
        else
        begin
            stage_v_reg <= stage_v_next;
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        box_ok_reg <= box_ok_next;
        if (en)
        begin
            lo_reg <= '{x: box_min_x, y: box_min_y, z: box_min_z};
            hi_reg <= '{x: box_max_x, y: box_max_y, z: box_max_z};
        end
    end

    cbl_axis_proj u_proj_u (
        .clk     (clk),
        .en      (en),
        .lo      (lo_reg),
        .hi      (hi_reg),
        .axis    (cfg.right_axis),
        .ext_min (ext.min_u),
        .ext_max (ext.max_u)
    );

    cbl_axis_proj u_proj_v (
        .clk     (clk),
        .en      (en),
        .lo      (lo_reg),
        .hi      (hi_reg),
        .axis    (cfg.up_axis),
        .ext_min (ext.min_v),
        .ext_max (ext.max_v)
    );

    cbl_axis_proj u_proj_w (
        .clk     (clk),
        .en      (en),
        .lo      (lo_reg),
        .hi      (hi_reg),
        .axis    (cfg.dir_axis),
        .ext_min (ext.min_w),
        .ext_max (ext.max_w)
    );

    cbl_classify u_classify (
        .clk       (clk),
        .en        (en),
        .box_ok    (box_ok_reg[Stages-2]),
        .ext       (ext),
        .cfg       (cfg),
        .cls       (cls),
        .ext_out   (ext_out),
        .near_clip (clipped_near),
        .far_clip  (clipped_far),
        .depth_in  (inside_depth),
        .depth_out (outside_depth)
    );

    assign result_valid    = stage_v_reg[Stages-1];
    assign footprint_class = cls;
    assign extent_min_u    = ext_out.min_u;
    assign extent_max_u    = ext_out.max_u;
    assign extent_min_v    = ext_out.min_v;
    assign extent_max_v    = ext_out.max_v;
    assign extent_min_w    = ext_out.min_w;
    assign extent_max_w    = ext_out.max_w;

endmodule

// File: sv/cbl_cfg_regs.sv
module cbl_cfg_regs
    import cbl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write word into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_RIGHT_AXIS: cfg_next.right_axis   = cfg_data[47:0];
                REG_UP_AXIS:    cfg_next.up_axis      = cfg_data[47:0];
                REG_DIR_AXIS:   cfg_next.dir_axis     = cfg_data[47:0];
                REG_U_LIMITS:   cfg_next.u_limits     = cfg_data;
                REG_V_LIMITS:   cfg_next.v_limits     = cfg_data;
                REG_DEPTH:      cfg_next.depth_limits = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.right_axis   <= RightAxisReset;
            cfg_reg.up_axis      <= UpAxisReset;
            cfg_reg.dir_axis     <= DirAxisReset;
            cfg_reg.u_limits     <= '0;
            cfg_reg.v_limits     <= '0;
            cfg_reg.depth_limits <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/cbl_axis_proj.sv
module cbl_axis_proj
    import cbl_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  vec3_t  lo,
    input  vec3_t  hi,
    input  axis_t  axis,
    output coord_t ext_min,
    output coord_t ext_max
);

    // Each corner picks lo or hi per coordinate on its own, so the corner
    // minimum is the sum of the per-coordinate minimum products. Floor and
    // clamp are monotonic and are applied once to that sum.
    coord_t lo_c [3];
    coord_t hi_c [3];
    comp_t  ax_c [3];

    prod_t prod_lo_reg  [3];
    prod_t prod_hi_reg  [3];
    prod_t prod_lo_next [3];
    prod_t prod_hi_next [3];
    prod_t term_min_reg  [3];
    prod_t term_max_reg  [3];
    prod_t term_min_next [3];
    prod_t term_max_next [3];
    coord_t ext_min_reg;
    coord_t ext_max_reg;
    coord_t ext_min_next;
    coord_t ext_max_next;
    psum_t  sum_min;
    psum_t  sum_max;

    assign lo_c[0] = lo.x;
    assign lo_c[1] = lo.y;
    assign lo_c[2] = lo.z;
    assign hi_c[0] = hi.x;
    assign hi_c[1] = hi.y;
    assign hi_c[2] = hi.z;
    assign ax_c[0] = axis[15:0];
    assign ax_c[1] = axis[31:16];
    assign ax_c[2] = axis[47:32];

    // Multiply both bounds by the basis component
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_lo_next[k] = mul_q(lo_c[k], ax_c[k]);
            prod_hi_next[k] = mul_q(hi_c[k], ax_c[k]);
        end
    end

    // Sort each product pair
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (prod_lo_reg[k] < prod_hi_reg[k])
            begin
                term_min_next[k] = prod_lo_reg[k];
                term_max_next[k] = prod_hi_reg[k];
            end
            else
            begin
                term_min_next[k] = prod_hi_reg[k];
                term_max_next[k] = prod_lo_reg[k];
            end
        end
    end

    // Add the three terms, floor to Q16.16 and clamp
    always_comb
    begin
        sum_min = psum_t'(term_min_reg[0]) + psum_t'(term_min_reg[1])
                + psum_t'(term_min_reg[2]);
        sum_max = psum_t'(term_max_reg[0]) + psum_t'(term_max_reg[1])
                + psum_t'(term_max_reg[2]);
        ext_min_next = sat_floor(sum_min);
        ext_max_next = sat_floor(sum_max);
    end

    // Advance all stages together
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_lo_reg  <= prod_lo_next;
            prod_hi_reg  <= prod_hi_next;
            term_min_reg <= term_min_next;
            term_max_reg <= term_max_next;
            ext_min_reg  <= ext_min_next;
            ext_max_reg  <= ext_max_next;
        end
    end

    assign ext_min = ext_min_reg;
    assign ext_max = ext_max_reg;

endmodule

// File: sv/cbl_classify.sv
module cbl_classify
    import cbl_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  logic    box_ok,
    input  extent_t ext,
    input  cfg_t    cfg,
    output class_t  cls,
    output extent_t ext_out,
    output logic    near_clip,
    output logic    far_clip,
    output logic    depth_in,
    output logic    depth_out
);

    coord_t umin;
    coord_t umax;
    coord_t vmin;
    coord_t vmax;
    coord_t near_w;
    coord_t far_w;
    logic   overlaps;
    logic   enclosed;

    class_t  cls_reg;
    class_t  cls_next;
    extent_t ext_reg;
    extent_t ext_next;
    logic    near_reg;
    logic    near_next;
    logic    far_reg;
    logic    far_next;
    logic    din_reg;
    logic    din_next;
    logic    dout_reg;
    logic    dout_next;

    assign umin   = cfg.u_limits[31:0];
    assign umax   = cfg.u_limits[63:32];
    assign vmin   = cfg.v_limits[31:0];
    assign vmax   = cfg.v_limits[63:32];
    assign near_w = cfg.depth_limits[31:0];
    assign far_w  = cfg.depth_limits[63:32];

    // Compare the extents against the receiver square and depth range
    always_comb
    begin
        overlaps = (ext.max_u >= umin) && (ext.min_u <= umax)
                && (ext.max_v >= vmin) && (ext.min_v <= vmax);
        enclosed = (ext.min_u > umin) && (ext.max_u < umax)
                && (ext.min_v > vmin) && (ext.max_v < vmax);

        cls_next  = CLS_INVALID;
        ext_next  = '0;
        near_next = 1'b0;
        far_next  = 1'b0;
        din_next  = 1'b0;
        dout_next = 1'b0;
        if (box_ok)
        begin
            priority if (!overlaps)
                cls_next = CLS_OUTSIDE;
            else if (enclosed)
                cls_next = CLS_INSIDE;
            else
                cls_next = CLS_STRADDLE;
            ext_next  = ext;
            near_next = ext.min_w < near_w;
            far_next  = ext.max_w > far_w;
            din_next  = !(ext.min_w < near_w) && !(ext.max_w > far_w);
            dout_next = (ext.max_w < near_w) || (ext.min_w > far_w);
        end
    end

    // Hold the result word while the receiver stalls
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls_reg  <= cls_next;
            ext_reg  <= ext_next;
            near_reg <= near_next;
            far_reg  <= far_next;
            din_reg  <= din_next;
            dout_reg <= dout_next;
        end
    end

    assign cls       = cls_reg;
    assign ext_out   = ext_reg;
    assign near_clip = near_reg;
    assign far_clip  = far_reg;
    assign depth_in  = din_reg;
    assign depth_out = dout_reg;

endmodule

// File: sv/cbl_checker.sv
module cbl_checker
    import cbl_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 item_stall,
    input logic                 result_valid,
    input logic                 result_stall,
    input logic [1:0]           footprint_class,
    input logic signed [31:0]   extent_min_u,
    input logic signed [31:0]   extent_max_u,
    input logic signed [31:0]   extent_min_v,
    input logic signed [31:0]   extent_max_v,
    input logic signed [31:0]   extent_min_w,
    input logic signed [31:0]   extent_max_w,
    input logic                 clipped_near,
    input logic                 clipped_far,
    input logic                 inside_depth,
    input logic                 outside_depth
);

    // An invalid box carries an all-zero result word
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && footprint_class == CLS_INVALID |->
            extent_min_u == 0 && extent_max_u == 0 && extent_min_v == 0 &&
            extent_max_v == 0 && extent_min_w == 0 && extent_max_w == 0 &&
            !clipped_near && !clipped_far && !inside_depth && !outside_depth)
        else $error("invalid box with nonzero result fields");

    // Depth flags agree for a valid box
    a_depth_flags: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && footprint_class != CLS_INVALID |->
            inside_depth == (!clipped_near && !clipped_far))
        else $error("inside_depth inconsistent with clip flags");

    // Extents are ordered for a valid box
    a_extent_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && footprint_class != CLS_INVALID |->
            extent_min_u <= extent_max_u && extent_min_v <= extent_max_v &&
            extent_min_w <= extent_max_w)
        else $error("extent minimum above maximum");

    // A stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(footprint_class) && $stable(extent_min_w))
        else $error("stalled result word changed");

    // Input is only held back while a result word is stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without output backpressure");

endmodule

bind caster_box_light_space_classifier_core cbl_checker u_cbl_checker (.*);
